FILE: rtl/blfb_pkg.sv
package blfb_pkg;

  localparam int PANEL_WIDTH  = 128;
  localparam int PANEL_HEIGHT = 64;
  localparam int PAGE_ROWS    = 8;
  localparam int STORE_DEPTH  = 1024;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int COORD_W      = 10;
  localparam int IDX_W        = 14;
  localparam int ERR_W        = 14;

  localparam logic [1:0] OP_DRAW  = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  typedef struct packed {
    logic load;
    logic step;
    logic pix_wr;
    logic sweep_wr;
    logic sel_index;
    logic cap_read;
    logic out_load;
  } blfb_cmd_t;

  typedef struct packed {
    logic on_panel;
    logic at_end;
    logic sweep_last;
    logic out_free;
  } blfb_sts_t;

endpackage

FILE: rtl/blfb_ctrl.sv
module blfb_ctrl
  import blfb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] opcode_i,
  input  blfb_sts_t  sts_i,
  output blfb_cmd_t  cmd_o
);

  typedef enum logic [7:0] {
    S_SWEEP_RST = 8'b0000_0001,
    S_IDLE      = 8'b0000_0010,
    S_PLOT      = 8'b0000_0100,
    S_WRITE     = 8'b0000_1000,
    S_RADDR     = 8'b0001_0000,
    S_RDATA     = 8'b0010_0000,
    S_SWEEP_CMD = 8'b0100_0000,
    S_DONE      = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP_RST;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_SWEEP_RST: begin
        cmd_o.sweep_wr = 1'b1;
        if (sts_i.sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          case (opcode_i)
            OP_DRAW:  state_d = S_PLOT;
            OP_CLEAR: state_d = S_SWEEP_CMD;
            OP_READ:  state_d = S_RADDR;
            default:  state_d = S_DONE;
          endcase
        end
      end
      S_PLOT: begin
        if (sts_i.on_panel) begin
          state_d = S_WRITE;
        end else if (sts_i.at_end) begin
          state_d = S_DONE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_WRITE: begin
        cmd_o.pix_wr = 1'b1;
        if (sts_i.at_end) begin
          state_d = S_DONE;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = S_PLOT;
        end
      end
      S_RADDR: begin
        cmd_o.sel_index = 1'b1;
        state_d         = S_RDATA;
      end
      S_RDATA: begin
        cmd_o.cap_read = 1'b1;
        state_d        = S_DONE;
      end
      S_SWEEP_CMD: begin
        cmd_o.sweep_wr = 1'b1;
        if (sts_i.sweep_last) state_d = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_SWEEP_RST;
    endcase
  end

endmodule

FILE: rtl/blfb_datapath.sv
module blfb_datapath
  import blfb_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  blfb_cmd_t                 cmd_i,
  output blfb_sts_t                 sts_o,
  input  logic signed [COORD_W-1:0] start_x_i,
  input  logic signed [COORD_W-1:0] start_y_i,
  input  logic signed [COORD_W-1:0] end_x_i,
  input  logic signed [COORD_W-1:0] end_y_i,
  input  logic                      pixel_value_i,
  input  logic [ADDR_W-1:0]         read_index_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [7:0]                read_data_o
);

  localparam logic signed [COORD_W:0] WidthS  = (COORD_W+1)'(PANEL_WIDTH);
  localparam logic signed [COORD_W:0] HeightS = (COORD_W+1)'(PANEL_HEIGHT);

  logic signed [COORD_W-1:0] x_q, y_q, xe_q, ye_q;
  logic signed [ERR_W-1:0]   dx_q, dy_q, err_q;
  logic                      sx_q, sy_q, on_q;
  logic [ADDR_W-1:0]         ridx_q;
  logic [ADDR_W-1:0]         sweep_q;
  logic [7:0]                res_q;
  logic [7:0]                out_data_q;
  logic                      out_valid_q;

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rdata_q;

  logic signed [COORD_W:0]   ddx, ddy;
  logic signed [ERR_W-1:0]   adx, ady;
  logic signed [ERR_W-1:0]   e2, err_d;
  logic                      mv_x, mv_y;
  logic [IDX_W-1:0]          idx_full;
  logic [ADDR_W-1:0]         pix_addr, rd_addr;
  logic [7:0]                bit_mask, wr_byte;

  assign ddx = (COORD_W+1)'(end_x_i) - (COORD_W+1)'(start_x_i);
  assign ddy = (COORD_W+1)'(end_y_i) - (COORD_W+1)'(start_y_i);
  assign adx = ddx[COORD_W] ? -ERR_W'(ddx) : ERR_W'(ddx);
  assign ady = ddy[COORD_W] ? -ERR_W'(ddy) : ERR_W'(ddy);

  assign e2    = err_q <<< 1;
  assign mv_x  = (e2 >= dy_q);
  assign mv_y  = (e2 <= dx_q);
  assign err_d = err_q + (mv_x ? dy_q : '0) + (mv_y ? dx_q : '0);

  assign idx_full = IDX_W'(y_q[7:3]) * IDX_W'(PANEL_WIDTH) + IDX_W'(x_q[7:0]);
  assign pix_addr = idx_full[ADDR_W-1:0];
  assign bit_mask = 8'(1) << y_q[2:0];
  assign wr_byte  = on_q ? (rdata_q | bit_mask) : (rdata_q & ~bit_mask);
  assign rd_addr  = cmd_i.sel_index ? ridx_q : pix_addr;

  assign sts_o.on_panel = !x_q[COORD_W-1] && !y_q[COORD_W-1] &&
                          ((COORD_W+1)'(x_q) < WidthS) &&
                          ((COORD_W+1)'(y_q) < HeightS) &&
                          (idx_full < IDX_W'(STORE_DEPTH));
  assign sts_o.at_end     = (x_q == xe_q) && (y_q == ye_q);
  assign sts_o.sweep_last = (sweep_q == ADDR_W'(STORE_DEPTH - 1));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_wr) begin
      mem[sweep_q] <= 8'h00;
    end else if (cmd_i.pix_wr) begin
      mem[pix_addr] <= wr_byte;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q    <= start_x_i;
      y_q    <= start_y_i;
      xe_q   <= end_x_i;
      ye_q   <= end_y_i;
      dx_q   <= adx;
      dy_q   <= -ady;
      err_q  <= adx - ady;
      sx_q   <= (start_x_i < end_x_i);
      sy_q   <= (start_y_i < end_y_i);
      on_q   <= pixel_value_i;
      ridx_q <= read_index_i;
    end else if (cmd_i.step) begin
      err_q <= err_d;
      if (mv_x) x_q <= sx_q ? x_q + COORD_W'(1) : x_q - COORD_W'(1);
      if (mv_y) y_q <= sy_q ? y_q + COORD_W'(1) : y_q - COORD_W'(1);
    end
    if (cmd_i.load) begin
      res_q <= 8'h00;
    end else if (cmd_i.cap_read) begin
      res_q <= rdata_q;
    end
    if (cmd_i.out_load) out_data_q <= res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.sweep_wr) sweep_q <= sweep_q + 1'b1;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;

endmodule

FILE: rtl/bresenham_line_framebuffer_unit.sv
// Channel   Handshake                 Payload
// input     in_valid_i / in_ready_o   opcode_i, start_x_i, start_y_i, end_x_i, end_y_i,
//                                     pixel_value_i, read_index_i
// output    out_valid_o / out_ready_i read_data_o
//
// One command at a time. Draw: each on-panel pixel takes a store read, then a write;
// an off-panel pixel is stepped past. Read: store address, then data capture. Clear: one byte per cycle.
// After reset a sweep zeroes all 1024 store bytes; in_ready_o stays low until it ends.
// The result sits in an output register; the next command is taken while it waits.
module bresenham_line_framebuffer_unit
  import blfb_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                opcode_i,
  input  logic signed [COORD_W-1:0] start_x_i,
  input  logic signed [COORD_W-1:0] start_y_i,
  input  logic signed [COORD_W-1:0] end_x_i,
  input  logic signed [COORD_W-1:0] end_y_i,
  input  logic                      pixel_value_i,
  input  logic [ADDR_W-1:0]         read_index_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [7:0]                read_data_o
);

  blfb_cmd_t cmd;
  blfb_sts_t sts;

  blfb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  blfb_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .pixel_value_i (pixel_value_i),
    .read_index_i  (read_index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .read_data_o   (read_data_o)
  );

endmodule
